// File: rtl/oost_pkg.sv
package oost_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int ADDR_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 24;
  localparam int FRAME_W    = 2 * SAMPLE_W;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int PROD_W     = SAMPLE_W + CNT_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W + 1);
  localparam int HIT_W      = SAMPLE_W + 7;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH = 1'b1;

  localparam logic [CFG_W-1:0] MAX_LENGTH_RESET  = CFG_W'(65536);
  localparam logic [CFG_W-1:0] FADE_LENGTH_RESET = CFG_W'(241);

  // Onset gate: a sample opens the gate when GATE_SCALE * |v| >= peak.
  localparam logic [HIT_W-1:0] GATE_SCALE = HIT_W'(100);

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_PROCESS = 2'd2,
    OP_READ    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_SILENT   = 2'd2,
    STAT_PAST_END = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RDWAIT,
    S_PK1,
    S_PK1_END,
    S_SILENT,
    S_ONSET,
    S_TRIM,
    S_FADE_INIT,
    S_FADE_CHK,
    S_FADE_RD,
    S_FADE_MUL,
    S_FADE_START,
    S_FADE_DIV,
    S_FADE_WR,
    S_PK2_INIT,
    S_PK2,
    S_PK2_END,
    S_EMIT_OK,
    S_EMIT_SIL
  } state_t;

  typedef enum logic [1:0] {
    RA_READ,
    RA_SWEEP,
    RA_FADE
  } raddr_sel_t;

  typedef struct packed {
    logic       sweep_clr;
    logic       sweep_en;
    logic       onset_mode;
    logic       latch_peak;
    logic       silent_set;
    logic       trim_set;
    logic       fade_init;
    logic       fade_mul;
    logic       div_start;
    logic       fade_wr;
    logic       emit_rd;
    logic       emit_proc;
    status_t    emit_status;
    raddr_sel_t raddr_sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic sweep_done;
    logic silent;
    logic trunc;
    logic fade_done;
    logic div_busy;
  } stat_t;

  function automatic logic [SAMPLE_W-1:0] mag(input logic [SAMPLE_W-1:0] v);
    return v[SAMPLE_W-1] ? SAMPLE_W'(-v) : v;
  endfunction

endpackage

// File: rtl/oost_req_if.sv
interface oost_req_if import oost_pkg::*; ();
  logic                valid;
  logic                ready;
  opcode_t             opcode;
  logic [SAMPLE_W-1:0] left_in;
  logic [SAMPLE_W-1:0] right_in;

  modport source (output valid, output opcode, output left_in, output right_in, input ready);
  modport sink   (input valid, input opcode, input left_in, input right_in, output ready);
endinterface

// File: rtl/oost_rsp_if.sv
interface oost_rsp_if import oost_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_out;
  logic [SAMPLE_W-1:0] right_out;
  logic                last_frame;
  logic [CNT_W-1:0]    frame_count;
  logic [SAMPLE_W-1:0] peak_level;
  logic                was_truncated;
  status_t             status;

  modport source (output valid, output left_out, output right_out, output last_frame,
                  output frame_count, output peak_level, output was_truncated,
                  output status, input ready);
  modport sink   (input valid, input left_out, input right_out, input last_frame,
                  input frame_count, input peak_level, input was_truncated,
                  input status, output ready);
endinterface

// File: rtl/oost_div.sv
module oost_div import oost_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic [PROD_W-1:0] quotient,
  output logic              busy
);

  logic [CNT_W-1:0]     rem;
  logic [PROD_W-1:0]    q;
  logic [DIV_CNT_W-1:0] count;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 ge;

  assign trial    = {rem, q[PROD_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = trial >= {1'b0, divisor};
  assign busy     = count != '0;
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= DIV_CNT_W'(PROD_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
    end else if (busy) begin
      q   <= {q[PROD_W-2:0], ge};
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

endmodule

// File: rtl/oost_ctrl.sv
module oost_ctrl import oost_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  opcode_t opcode,
  input  stat_t   stat,
  output logic    ready,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_READ) begin
            state_next = S_RDWAIT;
          end else if (opcode == OP_PROCESS) begin
            state_next = S_PK1;
          end
        end
      end
      S_RDWAIT:     state_next = S_IDLE;
      S_PK1:        if (stat.sweep_done) state_next = S_PK1_END;
      S_PK1_END:    state_next = stat.silent ? S_SILENT : S_ONSET;
      S_SILENT:     state_next = S_EMIT_SIL;
      S_ONSET:      if (stat.sweep_done) state_next = S_TRIM;
      S_TRIM:       state_next = S_FADE_INIT;
      S_FADE_INIT:  state_next = S_FADE_CHK;
      S_FADE_CHK: begin
        if (!stat.trunc || stat.fade_done) begin
          state_next = S_PK2_INIT;
        end else begin
          state_next = S_FADE_RD;
        end
      end
      S_FADE_RD:    state_next = S_FADE_MUL;
      S_FADE_MUL:   state_next = S_FADE_START;
      S_FADE_START: state_next = S_FADE_DIV;
      S_FADE_DIV:   if (!stat.div_busy) state_next = S_FADE_WR;
      S_FADE_WR:    state_next = S_FADE_CHK;
      S_PK2_INIT:   state_next = S_PK2;
      S_PK2:        if (stat.sweep_done) state_next = S_PK2_END;
      S_PK2_END:    state_next = S_EMIT_OK;
      S_EMIT_OK:    state_next = S_IDLE;
      S_EMIT_SIL:   state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.raddr_sel   = RA_READ;
    cmd.emit_status = STAT_OK;
    ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        ready         = stat.out_free;
        cmd.sweep_clr = 1'b1;
      end
      S_RDWAIT:     cmd.emit_rd = 1'b1;
      S_PK1: begin
        cmd.sweep_en  = 1'b1;
        cmd.raddr_sel = RA_SWEEP;
      end
      S_PK1_END: begin
        cmd.latch_peak = 1'b1;
        cmd.sweep_clr  = 1'b1;
      end
      S_SILENT:     cmd.silent_set = 1'b1;
      S_ONSET: begin
        cmd.sweep_en   = 1'b1;
        cmd.onset_mode = 1'b1;
        cmd.raddr_sel  = RA_SWEEP;
      end
      S_TRIM:       cmd.trim_set = 1'b1;
      S_FADE_INIT:  cmd.fade_init = 1'b1;
      S_FADE_CHK:   cmd.raddr_sel = RA_FADE;
      S_FADE_RD:    cmd.raddr_sel = RA_FADE;
      S_FADE_MUL:   cmd.fade_mul = 1'b1;
      S_FADE_START: cmd.div_start = 1'b1;
      S_FADE_DIV:   cmd.raddr_sel = RA_FADE;
      S_FADE_WR:    cmd.fade_wr = 1'b1;
      S_PK2_INIT:   cmd.sweep_clr = 1'b1;
      S_PK2: begin
        cmd.sweep_en  = 1'b1;
        cmd.raddr_sel = RA_SWEEP;
      end
      S_PK2_END:    cmd.latch_peak = 1'b1;
      S_EMIT_OK:    cmd.emit_proc = 1'b1;
      S_EMIT_SIL: begin
        cmd.emit_proc   = 1'b1;
        cmd.emit_status = STAT_SILENT;
      end
      default:      cmd.sweep_clr = 1'b1;
    endcase
  end

endmodule

// File: rtl/oost_datapath.sv
module oost_datapath import oost_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  opcode_t              opcode,
  input  logic [SAMPLE_W-1:0]  left_in,
  input  logic [SAMPLE_W-1:0]  right_in,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  oost_rsp_if.source           rsp
);

  logic [FRAME_W-1:0] mem [MAX_FRAMES];
  logic [FRAME_W-1:0] rdata;
  logic [ADDR_W-1:0]  raddr, waddr, base;
  logic [FRAME_W-1:0] wdata;
  logic               we;

  logic [CFG_W-1:0]    max_length, fade_length;
  logic [CNT_W-1:0]    loaded, trimmed, rdptr, cnt, onset, fade, fidx, rd_i, fk;
  logic [SAMPLE_W-1:0] peak, acc;
  logic                trunc, found, rd_v, rd_ok, rd_last, issue, full;

  logic [SAMPLE_W-1:0] mag_l, mag_r, m1;
  logic [HIT_W-1:0]    hit_l, hit_r;
  logic                hit;
  logic [CNT_W:0]      lim;
  logic [CNT_W-1:0]    ml_eff, trim_end, trim_len;

  logic [PROD_W-1:0]   prod_l, prod_r, quo_l, quo_r;
  logic                sign_l, sign_r, busy_l, busy_r;
  logic [SAMPLE_W-1:0] fl_l, fl_r;

  logic                o_valid, o_last, o_trunc;
  logic [SAMPLE_W-1:0] o_l, o_r, o_peak;
  logic [CNT_W-1:0]    o_count;
  status_t             o_status;

  assign full  = loaded >= CNT_W'(MAX_FRAMES);
  assign fk    = trimmed - fidx - 1'b1;
  assign issue = cmd.sweep_en && (cnt < loaded) && !(cmd.onset_mode && found);

  always_comb begin
    case (cmd.raddr_sel)
      RA_SWEEP: raddr = base + cnt[ADDR_W-1:0];
      RA_FADE:  raddr = base + fk[ADDR_W-1:0];
      default:  raddr = base + rdptr[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    if (cmd.fade_wr) begin
      we    = 1'b1;
      waddr = base + fk[ADDR_W-1:0];
      wdata = {fl_l, fl_r};
    end else begin
      we    = accept && (opcode == OP_LOAD) && !full;
      waddr = base + loaded[ADDR_W-1:0];
      wdata = {left_in, right_in};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign mag_l = mag(rdata[FRAME_W-1:SAMPLE_W]);
  assign mag_r = mag(rdata[SAMPLE_W-1:0]);
  assign m1    = (mag_l > acc) ? mag_l : acc;
  assign hit_l = HIT_W'(mag_l) * GATE_SCALE;
  assign hit_r = HIT_W'(mag_r) * GATE_SCALE;
  assign hit   = (hit_l >= HIT_W'(peak)) || (hit_r >= HIT_W'(peak));

  // Sweep over the stored frames: one read issued per cycle, checked the cycle after.
  always_ff @(posedge clk) begin
    if (cmd.sweep_clr) begin
      cnt   <= '0;
      acc   <= '0;
      found <= 1'b0;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= issue;
      rd_i <= cnt;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (rd_v) begin
        acc <= (mag_r > m1) ? mag_r : m1;
        if (cmd.onset_mode && !found && hit) begin
          found <= 1'b1;
          onset <= rd_i;
        end
      end
    end
  end

  assign ml_eff   = (max_length == '0) ? CNT_W'(1) : max_length;
  assign lim      = {1'b0, onset} + {1'b0, ml_eff};
  assign trim_end = (lim < {1'b0, loaded}) ? lim[CNT_W-1:0] : loaded;
  assign trim_len = trim_end - onset;

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded      <= '0;
      trimmed     <= '0;
      rdptr       <= '0;
      peak        <= '0;
      trunc       <= 1'b0;
      base        <= '0;
      max_length  <= MAX_LENGTH_RESET;
      fade_length <= FADE_LENGTH_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_LENGTH:  max_length  <= cfg_data;
          REG_FADE_LENGTH: fade_length <= cfg_data;
          default:         max_length  <= max_length;
        endcase
      end
      if (accept) begin
        unique case (opcode)
          OP_CLEAR: begin
            loaded  <= '0;
            trimmed <= '0;
            rdptr   <= '0;
            peak    <= '0;
            trunc   <= 1'b0;
            base    <= '0;
          end
          OP_LOAD: begin
            if (!full) begin
              loaded <= loaded + 1'b1;
            end
          end
          OP_PROCESS: begin
            rdptr <= '0;
            trunc <= 1'b0;
          end
          OP_READ: begin
            if (rdptr < trimmed) begin
              rdptr <= rdptr + 1'b1;
            end
          end
          default: rdptr <= rdptr;
        endcase
      end
      if (cmd.latch_peak) begin
        peak <= acc;
      end
      if (cmd.silent_set) begin
        peak    <= '0;
        trimmed <= loaded;
      end
      if (cmd.trim_set) begin
        trunc   <= lim < {1'b0, loaded};
        trimmed <= trim_len;
        loaded  <= trim_len;
        base    <= base + onset[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_READ) begin
      rd_ok   <= rdptr < trimmed;
      rd_last <= (rdptr + 1'b1) == trimmed;
    end
    if (cmd.fade_init) begin
      fade <= (fade_length < trimmed) ? fade_length : trimmed;
      fidx <= '0;
    end else if (cmd.fade_wr) begin
      fidx <= fidx + 1'b1;
    end
    if (cmd.fade_mul) begin
      prod_l <= PROD_W'(mag_l) * PROD_W'(fidx);
      prod_r <= PROD_W'(mag_r) * PROD_W'(fidx);
      sign_l <= rdata[FRAME_W-1];
      sign_r <= rdata[SAMPLE_W-1];
    end
  end

  oost_div u_div_l (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_l),
    .divisor  (fade),
    .quotient (quo_l),
    .busy     (busy_l)
  );

  oost_div u_div_r (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (fade),
    .quotient (quo_r),
    .busy     (busy_r)
  );

  // The faded magnitude never exceeds the original, so it fits the sample width.
  assign fl_l = sign_l ? SAMPLE_W'(-quo_l[SAMPLE_W-1:0]) : quo_l[SAMPLE_W-1:0];
  assign fl_r = sign_r ? SAMPLE_W'(-quo_r[SAMPLE_W-1:0]) : quo_r[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (accept && (opcode == OP_CLEAR || opcode == OP_LOAD)) begin
      o_valid <= 1'b1;
    end else if (cmd.emit_rd || cmd.emit_proc) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_CLEAR) begin
      o_l      <= '0;
      o_r      <= '0;
      o_last   <= 1'b0;
      o_count  <= '0;
      o_peak   <= '0;
      o_trunc  <= 1'b0;
      o_status <= STAT_OK;
    end else if (accept && opcode == OP_LOAD) begin
      o_l      <= '0;
      o_r      <= '0;
      o_last   <= 1'b0;
      o_count  <= full ? loaded : loaded + 1'b1;
      o_peak   <= peak;
      o_trunc  <= trunc;
      o_status <= full ? STAT_FULL : STAT_OK;
    end else if (cmd.emit_rd) begin
      o_l      <= rd_ok ? rdata[FRAME_W-1:SAMPLE_W] : '0;
      o_r      <= rd_ok ? rdata[SAMPLE_W-1:0] : '0;
      o_last   <= rd_ok && rd_last;
      o_count  <= trimmed;
      o_peak   <= peak;
      o_trunc  <= trunc;
      o_status <= rd_ok ? STAT_OK : STAT_PAST_END;
    end else if (cmd.emit_proc) begin
      o_l      <= '0;
      o_r      <= '0;
      o_last   <= 1'b0;
      o_count  <= trimmed;
      o_peak   <= peak;
      o_trunc  <= trunc;
      o_status <= cmd.emit_status;
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.left_out      = o_l;
  assign rsp.right_out     = o_r;
  assign rsp.last_frame    = o_last;
  assign rsp.frame_count   = o_count;
  assign rsp.peak_level    = o_peak;
  assign rsp.was_truncated = o_trunc;
  assign rsp.status        = o_status;

  assign stat.out_free   = !o_valid || rsp.ready;
  assign stat.sweep_done = cmd.sweep_en && !issue && !rd_v;
  assign stat.silent     = (loaded == '0) || (acc == '0);
  assign stat.trunc      = trunc;
  assign stat.fade_done  = fidx == fade;
  assign stat.div_busy   = busy_l || busy_r;

endmodule

// File: rtl/one_shot_onset_trim_fade.sv
// Clear and load are done in the idle state; read goes through one memory read stage.
// Process sweeps the loaded frames for the peak, sweeps them again for the onset unless
// the sound is silent, trims, fades the kept tail frame by frame when the tail is cut,
// and sweeps the kept frames for the new peak; each faded frame waits for the bit-serial
// dividers. A single result register holds each result; the next item is taken in the
// idle state once it is empty or being drained. Synchronous active-high reset clears the
// frame counters, peak, flag and output valid; the frame memory is not cleared.
module one_shot_onset_trim_fade import oost_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  oost_req_if.sink             req,
  oost_rsp_if.source           rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t  cmd;
  stat_t stat;
  logic  ready;
  logic  accept;

  assign req.ready = ready;
  assign accept    = req.valid && ready;

  oost_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (req.opcode),
    .stat   (stat),
    .ready  (ready),
    .cmd    (cmd)
  );

  oost_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (req.opcode),
    .left_in   (req.left_in),
    .right_in  (req.right_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

// File: bench/tb_one_shot_onset_trim_fade.sv
module tb_one_shot_onset_trim_fade;
  import oost_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 600000;
  localparam int RX_HOLD_CYCLES  = 300;

  typedef struct {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                last;
    logic [CNT_W-1:0]    count;
    logic [SAMPLE_W-1:0] peak;
    logic                trunc;
    status_t             status;
  } frame_rsp_t;

  typedef struct {
    opcode_t             op;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    bit                  typed;
    frame_rsp_t          rsp;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  oost_req_if req ();
  oost_rsp_if rsp ();

  one_shot_onset_trim_fade i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req.sink),
    .rsp      (rsp.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Model of the block: frame store, counters and configuration.
  logic signed [SAMPLE_W-1:0] pcm_l [MAX_FRAMES];
  logic signed [SAMPLE_W-1:0] pcm_r [MAX_FRAMES];
  int unsigned n_loaded, n_trimmed, rd_ptr, peak_now, keep_max, fade_max;
  bit          cut_flag;

  frame_rsp_t pending_rsp[$];
  dir_row_t   dir_rows[$];
  int n_fail, n_items, n_rsp, n_process, n_cut, idle_cnt;
  bit idle_on, rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned sample_mag(logic signed [SAMPLE_W-1:0] v);
    int s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  function automatic int unsigned scan_peak(int unsigned n);
    int unsigned p;
    p = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (sample_mag(pcm_l[i]) > p) p = sample_mag(pcm_l[i]);
      if (sample_mag(pcm_r[i]) > p) p = sample_mag(pcm_r[i]);
    end
    return p;
  endfunction

  function automatic status_t trim_and_fade();
    int unsigned onset, lim, stop, fade, k;
    longint prod;
    rd_ptr = 0;
    cut_flag = 1'b0;
    peak_now = scan_peak(n_loaded);
    if (n_loaded == 0 || peak_now == 0) begin
      peak_now = 0;
      n_trimmed = n_loaded;
      return STAT_SILENT;
    end
    onset = n_loaded;
    for (int unsigned i = 0; i < n_loaded; i++) begin
      if (longint'(sample_mag(pcm_l[i])) * 100 >= peak_now ||
          longint'(sample_mag(pcm_r[i])) * 100 >= peak_now) begin
        onset = i;
        break;
      end
    end
    lim = onset + ((keep_max == 0) ? 1 : keep_max);
    stop = (lim < n_loaded) ? lim : n_loaded;
    cut_flag = stop < n_loaded;
    n_trimmed = stop - onset;
    for (int unsigned i = 0; i < n_trimmed; i++) begin
      pcm_l[i] = pcm_l[onset + i];
      pcm_r[i] = pcm_r[onset + i];
    end
    n_loaded = n_trimmed;
    if (cut_flag) begin
      fade = (fade_max < n_trimmed) ? fade_max : n_trimmed;
      for (int unsigned i = 0; i < fade; i++) begin
        k = n_trimmed - 1 - i;
        prod = longint'(pcm_l[k]) * longint'(i);
        pcm_l[k] = SAMPLE_W'(prod / longint'(fade));
        prod = longint'(pcm_r[k]) * longint'(i);
        pcm_r[k] = SAMPLE_W'(prod / longint'(fade));
      end
    end
    peak_now = scan_peak(n_trimmed);
    return STAT_OK;
  endfunction

  function automatic frame_rsp_t predict_frame(opcode_t op, logic [SAMPLE_W-1:0] l,
                                               logic [SAMPLE_W-1:0] r);
    frame_rsp_t e;
    e = '{left: '0, right: '0, last: 1'b0, count: '0, peak: '0, trunc: 1'b0,
          status: STAT_OK};
    case (op)
      OP_CLEAR: begin
        n_loaded = 0; n_trimmed = 0; rd_ptr = 0; peak_now = 0; cut_flag = 1'b0;
        e.count = '0;
      end
      OP_LOAD: begin
        if (n_loaded < MAX_FRAMES) begin
          pcm_l[n_loaded] = l;
          pcm_r[n_loaded] = r;
          n_loaded++;
        end else begin
          e.status = STAT_FULL;
        end
        e.count = CNT_W'(n_loaded);
      end
      OP_PROCESS: begin
        e.status = trim_and_fade();
        e.count = CNT_W'(n_trimmed);
        n_process++;
        if (cut_flag) n_cut++;
      end
      default: begin
        if (rd_ptr < n_trimmed && rd_ptr < MAX_FRAMES) begin
          e.left = pcm_l[rd_ptr];
          e.right = pcm_r[rd_ptr];
          e.last = (rd_ptr + 1 == n_trimmed);
          rd_ptr++;
        end else begin
          e.status = STAT_PAST_END;
        end
        e.count = CNT_W'(n_trimmed);
      end
    endcase
    e.peak = SAMPLE_W'(peak_now);
    e.trunc = cut_flag;
    return e;
  endfunction

  function automatic void add_row(opcode_t op, logic [SAMPLE_W-1:0] l,
                                  logic [SAMPLE_W-1:0] r, bit typed, frame_rsp_t want);
    dir_row_t row;
    row = '{op, l, r, typed, want};
    dir_rows = {dir_rows, row};
  endfunction

  // Drives one item and waits for the block to take it.
  task automatic send_item(opcode_t op, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                           bit typed = 1'b0,
                           frame_rsp_t typed_rsp = '{left: '0, right: '0, last: 1'b0,
                                                     count: '0, peak: '0, trunc: 1'b0,
                                                     status: STAT_OK});
    int gap;
    frame_rsp_t e;
    gap = 0;
    if (idle_on) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3: gap = $urandom_range(5, 30);
        default: gap = 0;
      endcase
    end
    @(negedge clk);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid = 1'b1;
    req.opcode = op;
    req.left_in = l;
    req.right_in = r;
    forever begin
      @(posedge clk);
      if (req.ready) break;
    end
    e = predict_frame(op, l, r);
    if (typed) e = typed_rsp;
    pending_rsp = {pending_rsp, e};
    n_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(int unsigned keep, int unsigned fade);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = REG_MAX_LENGTH;
    cfg_data = CFG_W'(keep);
    @(negedge clk);
    cfg_index = REG_FADE_LENGTH;
    cfg_data = CFG_W'(fade);
    @(negedge clk);
    cfg_we = 1'b0;
    keep_max = keep;
    fade_max = fade;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned scale);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      2: return SAMPLE_W'($signed($urandom_range(0, 200)) - 100);
      3, 4: return SAMPLE_W'($urandom);
      default: return SAMPLE_W'(int'($urandom_range(0, 2 * scale)) - int'(scale));
    endcase
  endfunction

  task automatic run_sound();
    int unsigned frames, lead, scale, extra;
    bit quiet;
    frames = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 30);
    lead = $urandom_range(0, 4);
    scale = 1 << $urandom_range(4, 23);
    quiet = $urandom_range(0, 9) == 0;
    if ($urandom_range(0, 4) != 0) send_item(OP_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    for (int unsigned i = 0; i < frames; i++) begin
      if (quiet) send_item(OP_LOAD, '0, '0);
      else if (i < lead)
        send_item(OP_LOAD, SAMPLE_W'(int'($urandom_range(0, scale / 64)) - int'(scale / 128)),
                  SAMPLE_W'(int'($urandom_range(0, scale / 64)) - int'(scale / 128)));
      else send_item(OP_LOAD, pick_sample(scale), pick_sample(scale));
    end
    send_item(OP_PROCESS, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      extra = $urandom_range(1, 4);
      repeat (extra) send_item(OP_LOAD, pick_sample(scale), pick_sample(scale));
    end
    repeat ($urandom_range(0, frames + 2)) send_item(OP_READ, SAMPLE_W'($urandom),
                                                      SAMPLE_W'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      send_item(OP_PROCESS, '0, '0);
      repeat ($urandom_range(1, 6)) send_item(OP_READ, '0, '0);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off when asked.
  initial begin
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rsp.ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
        rsp.ready = 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 4) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(5, 30)) @(negedge clk);
        rsp.ready = 1'b1;
      end else begin
        rsp.ready = !idle_on || ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    frame_rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: result with nothing expected", $realtime);
        n_fail++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.left_out !== e.left) begin
          $display("%0t: left_out exp %h got %h", $realtime, e.left, rsp.left_out);
          n_fail++;
        end
        if (rsp.right_out !== e.right) begin
          $display("%0t: right_out exp %h got %h", $realtime, e.right, rsp.right_out);
          n_fail++;
        end
        if (rsp.last_frame !== e.last) begin
          $display("%0t: last_frame exp %b got %b", $realtime, e.last, rsp.last_frame);
          n_fail++;
        end
        if (rsp.frame_count !== e.count) begin
          $display("%0t: frame_count exp %0d got %0d", $realtime, e.count, rsp.frame_count);
          n_fail++;
        end
        if (rsp.peak_level !== e.peak) begin
          $display("%0t: peak_level exp %h got %h", $realtime, e.peak, rsp.peak_level);
          n_fail++;
        end
        if (rsp.was_truncated !== e.trunc) begin
          $display("%0t: was_truncated exp %b got %b", $realtime, e.trunc, rsp.was_truncated);
          n_fail++;
        end
        if (rsp.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, e.status, rsp.status);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_CYCLES) begin
        $display("%0t: no progress, run stopped", $realtime);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    frame_rsp_t z;
    int unsigned keep_set[8];
    int unsigned fade_set[8];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_LENGTH;
    cfg_data = '0;
    req.valid = 1'b0;
    req.opcode = OP_CLEAR;
    req.left_in = '0;
    req.right_in = '0;
    n_fail = 0; n_items = 0; n_rsp = 0; n_process = 0; n_cut = 0;
    idle_on = 1'b1;
    rx_hold_req = 1'b0;
    n_loaded = 0; n_trimmed = 0; rd_ptr = 0; peak_now = 0; cut_flag = 1'b0;
    keep_max = MAX_LENGTH_RESET;
    fade_max = FADE_LENGTH_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    z = '{left: '0, right: '0, last: 1'b0, count: '0, peak: '0, trunc: 1'b0,
          status: STAT_OK};
    // Read and process on an empty store, then the sample extremes.
    add_row(OP_READ, 24'h123456, 24'h654321, 1'b1,
            '{'0, '0, 1'b0, '0, '0, 1'b0, STAT_PAST_END});
    add_row(OP_PROCESS, '0, '0, 1'b1,
            '{'0, '0, 1'b0, '0, '0, 1'b0, STAT_SILENT});
    add_row(OP_LOAD, 24'h7FFFFF, 24'h800000, 1'b1,
            '{'0, '0, 1'b0, 17'd1, '0, 1'b0, STAT_OK});
    add_row(OP_LOAD, 24'h000000, 24'hFFFFFF, 1'b0, z);
    add_row(OP_LOAD, 24'h000064, 24'hFFFF9C, 1'b0, z);
    add_row(OP_PROCESS, '0, '0, 1'b0, z);
    add_row(OP_READ, '0, '0, 1'b0, z);
    add_row(OP_LOAD, 24'h0000AA, 24'h000055, 1'b0, z);
    add_row(OP_READ, '0, '0, 1'b0, z);
    add_row(OP_READ, '0, '0, 1'b0, z);
    add_row(OP_READ, '0, '0, 1'b0, z);
    add_row(OP_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 1'b1, z);
    // Silent sound is kept as loaded.
    add_row(OP_LOAD, '0, '0, 1'b0, z);
    add_row(OP_LOAD, '0, '0, 1'b0, z);
    add_row(OP_PROCESS, '0, '0, 1'b1,
            '{'0, '0, 1'b0, 17'd2, '0, 1'b0, STAT_SILENT});
    add_row(OP_READ, '0, '0, 1'b0, z);
    // Onset gate exactly at one percent of a peak of 8388600.
    add_row(OP_CLEAR, '0, '0, 1'b1, z);
    add_row(OP_LOAD, SAMPLE_W'(-83885), 24'h0, 1'b0, z);
    add_row(OP_LOAD, 24'h0, SAMPLE_W'(83886), 1'b0, z);
    add_row(OP_LOAD, SAMPLE_W'(8388600), 24'h0, 1'b0, z);
    add_row(OP_PROCESS, '0, '0, 1'b0, z);
    add_row(OP_READ, '0, '0, 1'b0, z);
    add_row(OP_READ, '0, '0, 1'b0, z);
    add_row(OP_READ, '0, '0, 1'b0, z);
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].left, dir_rows[i].right, dir_rows[i].typed,
                dir_rows[i].rsp);

    keep_set = '{1, 3, 65536, 4, 0, 6, 10, 65536};
    fade_set = '{1, 65536, 65536, 2, 0, 1, 4, 241};
    for (int p = 0; n_items < 630; p++) begin
      if (p % 3 == 0) begin
        if (p / 3 < 8) write_cfg(keep_set[p / 3], fade_set[p / 3]);
        else write_cfg($urandom_range(1, 24), $urandom_range(0, 30));
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (p == 10) begin
        // Long receiver hold-off while reads keep coming.
        send_item(OP_CLEAR, '0, '0);
        repeat (12) send_item(OP_LOAD, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        send_item(OP_PROCESS, '0, '0);
        rx_hold_req = 1'b1;
        repeat (14) send_item(OP_READ, '0, '0);
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8))
          send_item(opcode_t'($urandom_range(0, 3)), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      end else begin
        run_sound();
      end
    end

    wait_drained();
    $display("Sent %0d items, checked %0d results; %0d processes, %0d with the tail cut.",
             n_items, n_rsp, n_process, n_cut);
    $display("Covered register extremes, silent sounds, the onset gate edge and a long stall.");
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/oost_pkg.sv
rtl/oost_req_if.sv
rtl/oost_rsp_if.sv
rtl/oost_div.sv
rtl/oost_ctrl.sv
rtl/oost_datapath.sv
rtl/one_shot_onset_trim_fade.sv
bench/tb_one_shot_onset_trim_fade.sv
